// ----- src/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while rst is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- src/u8v_pkg.sv -----
// types and constants for the utf-8 stream validator
// used by the front, queue, back and top level modules
package u8v_pkg;

   // classes a byte can fall into
   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_CONT,
      CLS_INVALID
   } byte_class_type;

   // classified byte carried from front to back
   typedef struct packed {
      byte_class_type cls;
      logic [5:0]     bits;
      logic           last;
   } class_item_type;

   // result of one byte
   typedef struct packed {
      logic string_valid;
      logic error_seen;
      logic string_done;
   } result_type;

   // lead byte ranges
   localparam logic [7:0] ASCII_MAX = 8'h7F;
   localparam logic [7:0] LEAD2_MIN = 8'hC2;
   localparam logic [7:0] LEAD2_MAX = 8'hDF;
   localparam logic [7:0] LEAD3_MIN = 8'hE0;
   localparam logic [7:0] LEAD3_MAX = 8'hEF;
   localparam logic [7:0] LEAD4_MIN = 8'hF0;
   localparam logic [7:0] LEAD4_MAX = 8'hF4;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;

   // code point limits
   localparam logic [20:0] MIN_CP3 = 21'h000800;
   localparam logic [20:0] MIN_CP4 = 21'h010000;
   localparam logic [20:0] MAX_CP  = 21'h10FFFF;
   localparam logic [20:0] SURR_LO = 21'h00D800;
   localparam logic [20:0] SURR_HI = 21'h00DFFF;

   // continuation counts of an open sequence
   localparam logic [1:0] SEQ_NONE = 2'd0;
   localparam logic [1:0] SEQ_LEN2 = 2'd1;
   localparam logic [1:0] SEQ_LEN3 = 2'd2;
   localparam logic [1:0] SEQ_LEN4 = 2'd3;

endpackage

// ----- src/u8v_front.sv -----
// front stage: classifies each incoming byte by its lead pattern
// depends on u8v_pkg
module u8v_front (
   input  logic [7:0]              data_byte,
   input  logic                    end_of_string,
   output u8v_pkg::class_item_type item
);
   import u8v_pkg::*;

   // byte class and payload bits
   always_comb begin
      item.last = end_of_string;
      item.bits = data_byte[5:0];
      if (data_byte <= ASCII_MAX) begin
         item.cls = CLS_ASCII;
      end else if ((data_byte & CONT_MASK) == CONT_TAG) begin
         item.cls = CLS_CONT;
      end else if (data_byte >= LEAD2_MIN && data_byte <= LEAD2_MAX) begin
         item.cls  = CLS_LEAD2;
         item.bits = {1'b0, data_byte[4:0]};
      end else if (data_byte >= LEAD3_MIN && data_byte <= LEAD3_MAX) begin
         item.cls  = CLS_LEAD3;
         item.bits = {2'b00, data_byte[3:0]};
      end else if (data_byte >= LEAD4_MIN && data_byte <= LEAD4_MAX) begin
         item.cls  = CLS_LEAD4;
         item.bits = {3'b000, data_byte[2:0]};
      end else begin
         item.cls = CLS_INVALID;
      end
   end

endmodule

// ----- src/u8v_queue.sv -----
// short queue of classified bytes between front and back
// depends on u8v_pkg
module u8v_queue #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  u8v_pkg::class_item_type push_item,
   output logic                    full,
   input  logic                    pop,
   output u8v_pkg::class_item_type pop_item,
   output logic                    not_empty
);
   import u8v_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   class_item_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = entries_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- src/u8v_back.sv -----
// back stage: sequence tracking, code point checks and result register
// depends on u8v_pkg
module u8v_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  u8v_pkg::class_item_type item,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output u8v_pkg::result_type     result
);
   import u8v_pkg::*;

   logic [1:0]  pend_ff, pend_in;
   logic [1:0]  len_ff, len_in;
   logic [20:0] acc_ff, acc_in;
   logic        err_ff, err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  result_ff, result_in;

   // take a byte when the result register is free or being drained
   assign pop       = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   // next state of the decoder
   always_comb begin
      logic [20:0] cp;
      logic        bad;
      pend_in      = pend_ff;
      len_in       = len_ff;
      acc_in       = acc_ff;
      err_in       = err_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cp           = {acc_ff[14:0], item.bits};
      bad          = 1'b0;
      if (pop) begin
         if (!err_ff) begin
            if (pend_ff == SEQ_NONE) begin
               unique case (item.cls)
                  CLS_ASCII: begin
                  end
                  CLS_LEAD2: begin
                     pend_in = SEQ_LEN2;
                     len_in  = SEQ_LEN2;
                     acc_in  = 21'(item.bits);
                  end
                  CLS_LEAD3: begin
                     pend_in = SEQ_LEN3;
                     len_in  = SEQ_LEN3;
                     acc_in  = 21'(item.bits);
                  end
                  CLS_LEAD4: begin
                     pend_in = SEQ_LEN4;
                     len_in  = SEQ_LEN4;
                     acc_in  = 21'(item.bits);
                  end
                  default: begin
                     err_in = 1'b1;
                  end
               endcase
            end else if (item.cls != CLS_CONT) begin
               err_in = 1'b1;
            end else begin
               acc_in  = cp;
               pend_in = pend_ff - 1'b1;
               if (pend_ff == SEQ_LEN2) begin
                  // sequence complete: reject overlongs, out of range, surrogates
                  bad = (len_ff == SEQ_LEN3 && cp < MIN_CP3) ||
                        (len_ff == SEQ_LEN4 && cp < MIN_CP4) ||
                        (cp > MAX_CP) ||
                        (cp >= SURR_LO && cp <= SURR_HI);
                  if (bad) begin
                     err_in = 1'b1;
                  end else begin
                     len_in = SEQ_NONE;
                     acc_in = '0;
                  end
               end
            end
         end
         // sequence cut short by the end of the string
         if (item.last && pend_in != SEQ_NONE) begin
            err_in = 1'b1;
         end
         if (err_in) begin
            pend_in = SEQ_NONE;
            len_in  = SEQ_NONE;
            acc_in  = '0;
         end
         result_in.string_valid = !err_in && (pend_in == SEQ_NONE);
         result_in.error_seen   = err_in;
         result_in.string_done  = item.last;
         rsp_valid_in           = 1'b1;
         // clear for the next string
         if (item.last) begin
            pend_in = SEQ_NONE;
            len_in  = SEQ_NONE;
            acc_in  = '0;
            err_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= SEQ_NONE;
         len_ff       <= SEQ_NONE;
         acc_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         len_ff       <= len_in;
         acc_ff       <= acc_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule

// ----- src/utf8_stream_validator_core.sv -----
// Strict UTF-8 checker for a byte stream, one byte per transfer with a flag on the
// final byte of each string. Every byte yields one result; the verdict on the flagged
// byte is final, after which all state clears for the next string. Throughput is one
// byte per cycle while the output is not stalled, set by the sequence state update in
// the back stage; an accepted byte reaches its result through the queue write, then the
// result register. A queue of QUEUE_DEPTH classified bytes separates input from output,
// so the input keeps taking bytes while the output is stalled until the queue is full.
module utf8_stream_validator_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_string_valid,
   output logic       rsp_error_seen,
   output logic       rsp_string_done
);
   import u8v_pkg::*;

   class_item_type front_item;
   class_item_type queue_item;
   result_type     result;
   logic           queue_full;
   logic           queue_not_empty;
   logic           queue_pop;
   logic           queue_push;

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;

   // classify incoming bytes
   u8v_front u_front (
      .data_byte     (req_data_byte),
      .end_of_string (req_end_of_string),
      .item          (front_item)
   );

   // decoupling queue
   u8v_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .not_empty (queue_not_empty)
   );

   // sequence tracking and result register
   u8v_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (queue_item),
      .pop        (queue_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .result     (result)
   );

   assign rsp_string_valid = result.string_valid;
   assign rsp_error_seen   = result.error_seen;
   assign rsp_string_done  = result.string_done;

endmodule

// ----- src/u8v_checker.sv -----
// port-level checks for the utf-8 stream validator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module u8v_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_byte,
   input logic       req_end_of_string,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_string_valid,
   input logic       rsp_error_seen,
   input logic       rsp_string_done
);

   // a stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_string_valid) && $stable(rsp_error_seen) && $stable(rsp_string_done))

   // a valid verdict never carries an error
   `ASSERT_IMPL(a_valid_no_err, clock, reset, rsp_valid && rsp_string_valid, !rsp_error_seen)

   // an error stays set until the string ends
   `ASSERT_NEXT(a_err_sticky, clock, reset, rsp_valid && !rsp_stall && rsp_error_seen && !rsp_string_done, !rsp_valid || rsp_error_seen)

   // no result right after reset
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind utf8_stream_validator_core u8v_checker u_checker (.*);

// ----- tb/testbench.sv -----
// testbench for utf8_stream_validator_core: a directed table of byte strings, then random
// strings, every result checked against a typed-in verdict or a behavioral model of strict utf-8 validation
// depends on u8v_pkg and utf8_stream_validator_core
module testbench;
   import u8v_pkg::*;

   localparam int RANDOM_BYTES = 1700;
   localparam int PHASE_LEN    = 150;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   // one byte of stimulus, with the verdict typed in where it is obvious
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       has_verdict;
      result_type verdict;
   } string_byte_type;

   // broken elements mixed into flawed strings
   typedef enum {
      FLAW_SURROGATE,
      FLAW_OVERLONG,
      FLAW_ABOVE_MAX,
      FLAW_TRUNCATED,
      FLAW_STRAY_CONT,
      FLAW_NOISE
   } flaw_kind_type;

   localparam result_type GOOD_MID = '{1'b1, 1'b0, 1'b0};
   localparam result_type GOOD_END = '{1'b1, 1'b0, 1'b1};
   localparam result_type OPEN_SEQ = '{1'b0, 1'b0, 1'b0};
   localparam result_type BAD_MID  = '{1'b0, 1'b1, 1'b0};
   localparam result_type BAD_END  = '{1'b0, 1'b1, 1'b1};
   localparam result_type NO_CHECK = '{1'b0, 1'b0, 1'b0};

   // directed strings: extremes, every lead class and each rejection rule
   localparam string_byte_type DIRECTED [26] = '{
      '{8'h00, 1'b0, 1'b1, GOOD_MID},   // ascii extremes in one string
      '{8'h7F, 1'b1, 1'b1, GOOD_END},
      '{8'h80, 1'b1, 1'b1, BAD_END},    // continuation where a lead is expected
      '{8'hFF, 1'b1, 1'b1, BAD_END},
      '{8'hC1, 1'b0, 1'b1, BAD_MID},    // lead of an overlong two-byte form
      '{8'h41, 1'b1, 1'b1, BAD_END},    // error stays set to the end of the string
      '{8'hC2, 1'b0, 1'b1, OPEN_SEQ},
      '{8'h41, 1'b1, 1'b1, BAD_END},    // non-continuation inside a sequence
      '{8'hDF, 1'b0, 1'b0, NO_CHECK},   // highest two-byte code point
      '{8'hBF, 1'b1, 1'b0, NO_CHECK},
      '{8'hE0, 1'b0, 1'b0, NO_CHECK},   // overlong three-byte form
      '{8'h9F, 1'b0, 1'b0, NO_CHECK},
      '{8'hBF, 1'b1, 1'b0, NO_CHECK},
      '{8'hED, 1'b0, 1'b0, NO_CHECK},   // lowest surrogate
      '{8'hA0, 1'b0, 1'b0, NO_CHECK},
      '{8'h80, 1'b1, 1'b0, NO_CHECK},
      '{8'hF0, 1'b0, 1'b0, NO_CHECK},   // overlong four-byte form
      '{8'h8F, 1'b0, 1'b0, NO_CHECK},
      '{8'hBF, 1'b0, 1'b0, NO_CHECK},
      '{8'hBF, 1'b1, 1'b0, NO_CHECK},
      '{8'hF4, 1'b0, 1'b0, NO_CHECK},   // just above the highest code point
      '{8'h90, 1'b0, 1'b0, NO_CHECK},
      '{8'h80, 1'b0, 1'b0, NO_CHECK},
      '{8'h80, 1'b1, 1'b0, NO_CHECK},
      '{8'hE2, 1'b0, 1'b1, OPEN_SEQ},   // sequence cut short by the end flag
      '{8'h82, 1'b1, 1'b1, BAD_END}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_string_valid;
   logic       rsp_error_seen;
   logic       rsp_string_done;

   string_byte_type stimulus[$];
   string_byte_type on_bus;
   result_type      expected_verdicts[$];
   int unsigned     transfers_in = 0;
   int unsigned     fail_count = 0;
   int unsigned     cycle_count = 0;

   // checker state mirrored from the block
   logic [1:0]  pending_conts = 2'd0;
   logic [1:0]  open_len = SEQ_NONE;
   logic [20:0] code_acc = '0;
   logic        sticky_err = 1'b0;

   utf8_stream_validator_core uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic void raise_sticky_error();
      sticky_err = 1'b1;
      pending_conts = 2'd0;
      open_len = SEQ_NONE;
      code_acc = '0;
   endfunction

   // verdict for one byte, advancing the mirrored state
   function automatic result_type predict_verdict(logic [7:0] b, logic last);
      result_type r;
      if (!sticky_err) begin
         if (pending_conts == 2'd0) begin
            if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
               pending_conts = 2'd1;
               open_len = SEQ_LEN2;
               code_acc = {16'd0, b[4:0]};
            end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
               pending_conts = 2'd2;
               open_len = SEQ_LEN3;
               code_acc = {17'd0, b[3:0]};
            end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
               pending_conts = 2'd3;
               open_len = SEQ_LEN4;
               code_acc = {18'd0, b[2:0]};
            end else if (b > ASCII_MAX) begin
               raise_sticky_error();
            end
         end else if ((b & CONT_MASK) != CONT_TAG) begin
            raise_sticky_error();
         end else begin
            code_acc = {code_acc[14:0], b[5:0]};
            pending_conts = pending_conts - 2'd1;
            // completed code point: overlong, out of range or surrogate
            if (pending_conts == 2'd0) begin
               if ((open_len == SEQ_LEN3 && code_acc < MIN_CP3) ||
                   (open_len == SEQ_LEN4 && code_acc < MIN_CP4) ||
                   code_acc > MAX_CP ||
                   (code_acc >= SURR_LO && code_acc <= SURR_HI)) begin
                  raise_sticky_error();
               end else begin
                  open_len = SEQ_NONE;
                  code_acc = '0;
               end
            end
         end
      end
      if (last && pending_conts != 2'd0)
         raise_sticky_error();
      r.string_valid = !sticky_err && pending_conts == 2'd0;
      r.error_seen = sticky_err;
      r.string_done = last;
      if (last) begin
         sticky_err = 1'b0;
         pending_conts = 2'd0;
         open_len = SEQ_NONE;
         code_acc = '0;
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0b, got %0b", name, want, got);
         fail_count++;
      end
   endfunction

   // legal code point needing n_bytes, bounds picked now and then
   function automatic logic [20:0] valid_code_point(int unsigned n_bytes);
      logic [20:0] cp;
      case (n_bytes)
         1: cp = 21'($urandom_range(ASCII_MAX));
         2: cp = 21'($urandom_range(MIN_CP3 - 1, 21'h80));
         3: begin
            cp = 21'($urandom_range(MIN_CP4 - 1, MIN_CP3));
            if (cp >= SURR_LO && cp <= SURR_HI)
               cp = ($urandom_range(1)) ? 21'(SURR_LO - 1) : 21'(SURR_HI + 1);
         end
         default: begin
            cp = 21'($urandom_range(MAX_CP, MIN_CP4));
            if ($urandom_range(7) == 0)
               cp = MAX_CP;
         end
      endcase
      return cp;
   endfunction

   // queue the first keep bytes of an n_bytes encoding of cp
   function automatic void append_char(logic [20:0] cp, int unsigned n_bytes,
                                       int unsigned keep);
      logic [7:0]      lead_tag;
      logic [20:0]     chunk;
      string_byte_type item;
      case (n_bytes)
         2: lead_tag = CONT_MASK;   // 110xxxxx
         3: lead_tag = LEAD3_MIN;   // 1110xxxx
         4: lead_tag = LEAD4_MIN;   // 11110xxx
         default: lead_tag = 8'h00;
      endcase
      for (int i = 0; i < keep; i++) begin
         chunk = cp >> (6 * (n_bytes - 1 - i));
         item = '0;
         item.data = (i == 0) ? (lead_tag | chunk[7:0]) : (CONT_TAG | {2'b00, chunk[5:0]});
         stimulus.insert(stimulus.size(), item);
      end
   endfunction

   // stimulus build, then wait for the drain and report
   initial begin
      int unsigned     n_chars;
      int unsigned     n_bytes;
      logic [20:0]     cp;
      bit              flawed;
      flaw_kind_type   flaw;
      string_byte_type tail;
      for (int i = 0; i < $size(DIRECTED); i++)
         stimulus.insert(stimulus.size(), DIRECTED[i]);
      while (stimulus.size() < $size(DIRECTED) + RANDOM_BYTES) begin
         flawed = ($urandom_range(99) < 30);
         n_chars = $urandom_range(8, 1);
         if ($urandom_range(99) < 8) begin
            // pure noise string
            for (int c = 0; c < n_chars; c++)
               append_char(21'($urandom_range(255)), 1, 1);
         end else begin
            for (int c = 0; c < n_chars; c++) begin
               if (flawed && $urandom_range(3) == 0) begin
                  flaw = flaw_kind_type'($urandom_range(5));
                  n_bytes = $urandom_range(4, 2);
                  case (flaw)
                     FLAW_SURROGATE: append_char(21'($urandom_range(SURR_HI, SURR_LO)), 3, 3);
                     FLAW_OVERLONG: begin
                        cp = (n_bytes == 2) ? 21'($urandom_range(ASCII_MAX)) :
                             (n_bytes == 3) ? 21'($urandom_range(MIN_CP3 - 1)) :
                                              21'($urandom_range(MIN_CP4 - 1));
                        append_char(cp, n_bytes, n_bytes);
                     end
                     FLAW_ABOVE_MAX:
                        append_char(21'($urandom_range(21'h1FFFFF, MAX_CP + 1)), 4, 4);
                     FLAW_TRUNCATED:
                        append_char(valid_code_point(n_bytes), n_bytes,
                                    $urandom_range(n_bytes - 1, 1));
                     FLAW_STRAY_CONT:
                        append_char(21'($urandom_range(8'hBF, CONT_TAG)), 1, 1);
                     default: append_char(21'($urandom_range(255)), 1, 1);
                  endcase
               end else begin
                  n_bytes = $urandom_range(3) + 1;
                  append_char(valid_code_point(n_bytes), n_bytes, n_bytes);
               end
            end
         end
         tail = stimulus.pop_back();
         tail.last = 1'b1;
         stimulus.insert(stimulus.size(), tail);
      end

      do @(negedge clock);
      while (stimulus.size() != 0 || req_valid || expected_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("** utf8_stream_validator_core: PASSED **");
      else
         $display("** utf8_stream_validator_core: FAILED **");
      $finish;
   end

   // both channels: predict on input transfers, check on result transfers
   always @(posedge clock) begin
      int unsigned idle_pct;
      int unsigned stall_pct;
      result_type  verdict;
      case ((transfers_in / PHASE_LEN) % 4)
         1: begin idle_pct = 79; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 79; end
         3: begin idle_pct = 25; stall_pct = 25; end
         default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            verdict = predict_verdict(req_data_byte, req_end_of_string);
            expected_verdicts.insert(expected_verdicts.size(),
                                     on_bus.has_verdict ? on_bus.verdict : verdict);
            transfers_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("result transfer with no expected verdict pending");
               fail_count++;
            end else begin
               verdict = expected_verdicts.pop_front();
               check_field("string_valid", verdict.string_valid, rsp_string_valid);
               check_field("error_seen", verdict.error_seen, rsp_error_seen);
               check_field("string_done", verdict.string_done, rsp_string_done);
            end
         end
         // next byte, payload held while stalled
         if (!(req_valid && req_stall)) begin
            if (stimulus.size() != 0 && $urandom_range(99) >= idle_pct) begin
               on_bus = stimulus.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= on_bus.data;
               req_end_of_string <= on_bus.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** utf8_stream_validator_core: FAILED **");
         $finish;
      end
   end

endmodule
